// ----- src/rmq_pkg.sv -----
package rmq_pkg;

    localparam int ELEM_W   = 16;
    localparam int DIFF_W   = 18;            // sum or difference of two elements
    localparam int RAD_W    = 17;            // clamped radicand, Q.14
    localparam int ROOT_W   = 18;            // sqrt result, Q.16
    localparam int SQ_STEPS = ROOT_W;        // one root bit per stage
    localparam int SQN_W    = 2 * ROOT_W;    // radicand shifted up by 18
    localparam int SQR_W    = ROOT_W + 3;    // partial remainder
    localparam int QUO_W    = 17;            // divider quotient bits
    localparam int DIV_STEPS = QUO_W;
    localparam int DNUM_W   = 34;            // |D|*32768 + q/2

    localparam logic signed [18:0] ONE_Q14 = 19'sd16384;

    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_X     = 2'd1,
        CASE_Y     = 2'd2,
        CASE_Z     = 2'd3
    } t_case;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [DIFF_W-1:0] t_diff;

endpackage

// ----- src/rmq_mat_if.sv -----
interface rmq_mat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

// ----- src/rmq_quat_if.sv -----
interface rmq_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic        [1:0]  case_taken;

    modport source (output valid, qx, qy, qz, qw, case_taken, input ready);
    modport sink   (input valid, qx, qy, qz, qw, case_taken, output ready);
endinterface

// ----- src/rmq_div_lane.sv -----
// Pipelined restoring divider: round(|d|*32768/q), signed and saturated.
// One prep stage plus one quotient bit per stage.
module rmq_div_lane (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  rmq_pkg::t_diff             i_d,
    input  logic [rmq_pkg::ROOT_W-1:0] i_q,
    output logic signed [15:0]         o_res
);
    import rmq_pkg::*;

    logic [DNUM_W-1:0] r_rem  [0:DIV_STEPS];
    logic [QUO_W-1:0]  r_quo  [0:DIV_STEPS];
    logic [ROOT_W-1:0] r_q    [0:DIV_STEPS];
    logic              r_neg  [0:DIV_STEPS];
    logic              r_zero [0:DIV_STEPS];
    logic              r_ovf  [0:DIV_STEPS];

    logic [DIFF_W-1:0] n_abs;
    logic [DNUM_W-1:0] n_num;

    always_comb begin
        n_abs = i_d[DIFF_W-1] ? (~i_d + 1'b1) : i_d;
        n_num = {2'b0, n_abs[QUO_W-1:0], 15'b0} + {{(DNUM_W-ROOT_W+1){1'b0}}, i_q[ROOT_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_num;
            r_quo[0]  <= '0;
            r_q[0]    <= i_q;
            r_neg[0]  <= i_d[DIFF_W-1];
            r_zero[0] <= (i_d == '0);
            r_ovf[0]  <= ({1'b0, n_num} >= {i_q, {QUO_W{1'b0}}});
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
        localparam int J = DIV_STEPS - s;
        logic [DNUM_W:0] n_cmp;
        logic            n_ge;
        always_comb begin
            n_cmp = {{(DNUM_W+1-ROOT_W){1'b0}}, r_q[s-1]} << J;
            n_ge  = ({1'b0, r_rem[s-1]} >= n_cmp);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_ge ? (r_rem[s-1] - n_cmp[DNUM_W-1:0]) : r_rem[s-1];
                r_quo[s]  <= r_quo[s-1] | (n_ge ? (QUO_W'(1) << J) : '0);
                r_q[s]    <= r_q[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
                r_ovf[s]  <= r_ovf[s-1];
            end
        end
    end

    always_comb begin
        logic [QUO_W-1:0] mag;
        mag = r_quo[DIV_STEPS];
        if (r_zero[DIV_STEPS]) begin
            o_res = '0;
        end else if (r_neg[DIV_STEPS]) begin
            if (r_ovf[DIV_STEPS] || mag[QUO_W-1] || mag[15])
                o_res = 16'sh8000;
            else
                o_res = -$signed(mag[15:0]);
        end else begin
            if (r_ovf[DIV_STEPS] || mag[QUO_W-1] || mag[15])
                o_res = 16'sh7fff;
            else
                o_res = $signed(mag[15:0]);
        end
    end
endmodule

// ----- src/rotation_matrix_to_quaternion_top.sv -----
// Channel   Dir  Payload
// i_mat     in   m00..m22, signed Q2.14
// o_quat    out  qx qy qz qw signed Q2.14, case_taken
//
// One matrix per cycle unless the output stalls; pipeline: front stage, 18 square-root
// stages, 18 divider stages, output register.
// The whole pipeline advances together; it stalls only when the output
// register holds a request that is not taken.
// Synchronous active-low reset clears the valid bits only.
module rotation_matrix_to_quaternion_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_mat_if.sink    i_mat,
    rmq_quat_if.source o_quat
);
    import rmq_pkg::*;

    // divider lanes hold a prep stage ahead of the quotient stages
    localparam int NSTG = 1 + SQ_STEPS + (DIV_STEPS + 1) + 1;

    logic             r_v [0:NSTG-1];
    logic             en;

    // square-root phase, index 0 is the front stage
    logic [SQN_W-1:0]  r_sn   [0:SQ_STEPS];
    logic [SQR_W-1:0]  r_srem [0:SQ_STEPS];
    logic [ROOT_W-1:0] r_root [0:SQ_STEPS];
    t_case             r_cs   [0:SQ_STEPS];
    t_diff             r_d    [0:SQ_STEPS][0:3];

    // divider phase sidebands
    t_case             r_dcs  [0:DIV_STEPS];
    logic [15:0]       r_dom  [0:DIV_STEPS];

    logic signed [15:0] lane_res [0:3];

    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    t_case              r_ocs;

    assign en          = !r_v[NSTG-1] || o_quat.ready;
    assign i_mat.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_mat.valid;
            for (int k = 1; k < NSTG; k++) r_v[k] <= r_v[k-1];
        end
    end

    // front: branch choice, radicand, off-diagonal terms
    t_case             n_cs;
    logic signed [18:0] n_r;
    t_diff             n_d [0:3];
    logic signed [17:0] n_tr;

    always_comb begin
        n_tr = 18'(i_mat.m00) + 18'(i_mat.m11) + 18'(i_mat.m22);
        for (int k = 0; k < 4; k++) n_d[k] = '0;
        if (n_tr > 0) begin
            n_cs   = CASE_TRACE;
            n_r    = ONE_Q14 + 19'(i_mat.m00) + 19'(i_mat.m11) + 19'(i_mat.m22);
            n_d[0] = 18'(i_mat.m21) - 18'(i_mat.m12);
            n_d[1] = 18'(i_mat.m02) - 18'(i_mat.m20);
            n_d[2] = 18'(i_mat.m10) - 18'(i_mat.m01);
        end else if (i_mat.m00 > i_mat.m11 && i_mat.m00 > i_mat.m22) begin
            n_cs   = CASE_X;
            n_r    = ONE_Q14 + 19'(i_mat.m00) - 19'(i_mat.m11) - 19'(i_mat.m22);
            n_d[3] = 18'(i_mat.m21) - 18'(i_mat.m12);
            n_d[1] = 18'(i_mat.m01) + 18'(i_mat.m10);
            n_d[2] = 18'(i_mat.m02) + 18'(i_mat.m20);
        end else if (i_mat.m11 > i_mat.m22) begin
            n_cs   = CASE_Y;
            n_r    = ONE_Q14 + 19'(i_mat.m11) - 19'(i_mat.m00) - 19'(i_mat.m22);
            n_d[3] = 18'(i_mat.m02) - 18'(i_mat.m20);
            n_d[0] = 18'(i_mat.m01) + 18'(i_mat.m10);
            n_d[2] = 18'(i_mat.m12) + 18'(i_mat.m21);
        end else begin
            n_cs   = CASE_Z;
            n_r    = ONE_Q14 + 19'(i_mat.m22) - 19'(i_mat.m00) - 19'(i_mat.m11);
            n_d[3] = 18'(i_mat.m10) - 18'(i_mat.m01);
            n_d[0] = 18'(i_mat.m02) + 18'(i_mat.m20);
            n_d[1] = 18'(i_mat.m12) + 18'(i_mat.m21);
        end
        if (n_r < 0) n_r = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sn[0]   <= {1'b0, n_r[RAD_W-1:0], {ROOT_W{1'b0}}};
            r_srem[0] <= '0;
            r_root[0] <= '0;
            r_cs[0]   <= n_cs;
            for (int k = 0; k < 4; k++) r_d[0][k] <= n_d[k];
        end
    end

    // digit-by-digit square root, two radicand bits per stage
    for (genvar s = 1; s <= SQ_STEPS; s++) begin : g_sq
        logic [SQR_W-1:0] n_rem2;
        logic [SQR_W-1:0] n_trial;
        logic             n_ge;
        always_comb begin
            n_rem2  = {r_srem[s-1][SQR_W-3:0], r_sn[s-1][SQN_W-1 -: 2]};
            n_trial = {1'b0, r_root[s-1], 2'b01};
            n_ge    = (n_rem2 >= n_trial);
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sn[s]   <= r_sn[s-1] << 2;
                r_srem[s] <= n_ge ? (n_rem2 - n_trial) : n_rem2;
                r_root[s] <= {r_root[s-1][ROOT_W-2:0], n_ge};
                r_cs[s]   <= r_cs[s-1];
                for (int k = 0; k < 4; k++) r_d[s][k] <= r_d[s-1][k];
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        rmq_div_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (r_d[SQ_STEPS][l]),
            .i_q   (r_root[SQ_STEPS]),
            .o_res (lane_res[l])
        );
    end

    logic [ROOT_W-1:0] n_qr;
    assign n_qr = r_root[SQ_STEPS] + ROOT_W'(4);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dcs[0] <= r_cs[SQ_STEPS];
            r_dom[0] <= {1'b0, n_qr[ROOT_W-1:3]};
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dcs[k] <= r_dcs[k-1];
                r_dom[k] <= r_dom[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ocs <= r_dcs[DIV_STEPS];
            r_qx  <= (r_dcs[DIV_STEPS] == CASE_X)     ? $signed(r_dom[DIV_STEPS]) : lane_res[0];
            r_qy  <= (r_dcs[DIV_STEPS] == CASE_Y)     ? $signed(r_dom[DIV_STEPS]) : lane_res[1];
            r_qz  <= (r_dcs[DIV_STEPS] == CASE_Z)     ? $signed(r_dom[DIV_STEPS]) : lane_res[2];
            r_qw  <= (r_dcs[DIV_STEPS] == CASE_TRACE) ? $signed(r_dom[DIV_STEPS]) : lane_res[3];
        end
    end

    assign o_quat.valid      = r_v[NSTG-1];
    assign o_quat.qx         = r_qx;
    assign o_quat.qy         = r_qy;
    assign o_quat.qz         = r_qz;
    assign o_quat.qw         = r_qw;
    assign o_quat.case_taken = r_ocs;
endmodule

// ----- src/rmq_chk.sv -----
module rmq_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_qx,
    input logic [15:0] i_qw,
    input logic [1:0]  i_case
);
    import rmq_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_qw) && $stable(i_qx))
        else $error("stalled result changed");

    // input side only stalls behind a held result
    a_ready: assert property (@(posedge i_clk)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result after reset");

    // dominant component is a square root, never negative
    a_dom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_case == CASE_TRACE) |-> !i_qw[15])
        else $error("negative w on trace branch");

    a_domx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_case == CASE_X) |-> !i_qx[15])
        else $error("negative x on x branch");
endmodule

bind rotation_matrix_to_quaternion_top rmq_chk u_rmq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_mat.ready),
    .i_out_valid (o_quat.valid),
    .i_out_ready (o_quat.ready),
    .i_qx        (o_quat.qx),
    .i_qw        (o_quat.qw),
    .i_case      (o_quat.case_taken)
);
